>>> rtl/particle_contact_impulse_assert.svh
// assertion macros for the particle contact impulse block
// no dependencies; included by the modules that carry assertions
`ifndef PARTICLE_CONTACT_IMPULSE_ASSERT_SVH
`define PARTICLE_CONTACT_IMPULSE_ASSERT_SVH
`ifndef SYNTHESIS
// condition implies consequence in the same cycle
`define PCI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// condition implies consequence in the next cycle
`define PCI_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PCI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define PCI_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/pcimp_pkg.sv
// types and constants of the particle contact impulse datapath
// no dependencies
package pcimp_pkg;

   localparam int SEP_W = 51;   // separating velocity, Q.30
   localparam int MAG_W = 35;   // approach speed, Q19.16
   localparam int FAC_W = 18;   // 1 + restitution, Q2.16
   localparam int DV_W  = 53;   // velocity change, Q.32
   localparam int TOT_W = 33;   // total inverse mass
   localparam int W_W   = 37;   // impulse times inverse mass
   localparam int SC_W  = 53;   // w times |normal|
   localparam logic [FAC_W-1:0] ONE_Q16 = 18'h10000;

   typedef enum logic [1:0] {
      OUT_SEPARATING = 2'd0,
      OUT_IMMOVABLE  = 2'd1,
      OUT_IMPULSE    = 2'd2
   } outcome_type;

   // payload carried along the pipeline
   typedef struct packed {
      logic [2:0][31:0] va;
      logic [2:0][31:0] vb;
      logic [2:0][15:0] n;
      logic [16:0]      bounce;
      logic [31:0]      ima;
      logic [31:0]      imb;
      outcome_type      outcome;
   } ctx_type;

   // clamp a 41-bit signed sum to the 32-bit range
   function automatic logic [31:0] sat32(input logic signed [40:0] v);
      logic [31:0] r;
      if (v > 41'sd2147483647) begin
         r = 32'h7fffffff;
      end else if (v < -41'sd2147483648) begin
         r = 32'h80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/particle_contact_impulse.sv
// particle contact impulse: deep pipeline with a bit-per-stage divider
// depends on pcimp_pkg and particle_contact_impulse_assert.svh
//
// usage: one contact enters on the req_ channel (req_valid high, req_stall
// low at a rising edge) and one result leaves on the rsp_ channel. A new
// contact may enter in every cycle in which req_stall is low.
// Stages: velocity differences, three products, dot product sum, outcome
// and approach speed, velocity change, 53 restoring divider stages (one
// quotient bit each, set by the 53-bit dividend), two stages for impulse
// times inverse mass, one for the normal scaling and one for the
// saturating add that feeds the output register.
// rsp_outcome: separating (unchanged), both immovable (unchanged) or
// impulse applied.
// When the receiver holds rsp_stall while a result is shown, the whole
// pipeline freezes and req_stall rises in the same cycle; nothing is lost
// or repeated. An empty output register never holds the pipeline.
// Synchronous reset clears all valid bits; payload registers are not reset.
`include "particle_contact_impulse_assert.svh"
module particle_contact_impulse
   import pcimp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_vel_a_x,
   input  logic [31:0] req_vel_a_y,
   input  logic [31:0] req_vel_a_z,
   input  logic [31:0] req_vel_b_x,
   input  logic [31:0] req_vel_b_y,
   input  logic [31:0] req_vel_b_z,
   input  logic [15:0] req_normal_x,
   input  logic [15:0] req_normal_y,
   input  logic [15:0] req_normal_z,
   input  logic [16:0] req_bounce,
   input  logic [31:0] req_inv_mass_a,
   input  logic [31:0] req_inv_mass_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_new_vel_a_x,
   output logic [31:0] rsp_new_vel_a_y,
   output logic [31:0] rsp_new_vel_a_z,
   output logic [31:0] rsp_new_vel_b_x,
   output logic [31:0] rsp_new_vel_b_y,
   output logic [31:0] rsp_new_vel_b_z,
   output logic [1:0]  rsp_outcome
);

   localparam int DIV_N = DV_W;

   logic    en;
   ctx_type req_ctx;

   // pipeline advances unless a shown result is held
   logic    rsp_valid_ff;
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // incoming request as a payload record
   always_comb begin
      req_ctx.va      = {req_vel_a_z, req_vel_a_y, req_vel_a_x};
      req_ctx.vb      = {req_vel_b_z, req_vel_b_y, req_vel_b_x};
      req_ctx.n       = {req_normal_z, req_normal_y, req_normal_x};
      req_ctx.bounce  = req_bounce;
      req_ctx.ima     = req_inv_mass_a;
      req_ctx.imb     = req_inv_mass_b;
      req_ctx.outcome = OUT_IMPULSE;
   end

   // stage 1: velocity differences
   logic             s1_vld_ff;
   ctx_type          s1_ctx_ff;
   logic [2:0][32:0] s1_diff_ff, s1_diff_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_diff_in[i] = {req_ctx.va[i][31], req_ctx.va[i]}
                       - {req_ctx.vb[i][31], req_ctx.vb[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
      end
      if (en) begin
         s1_ctx_ff  <= req_ctx;
         s1_diff_ff <= s1_diff_in;
      end
   end

   // stage 2: per-axis products with the normal
   logic             s2_vld_ff;
   ctx_type          s2_ctx_ff;
   logic [2:0][48:0] s2_prod_ff, s2_prod_in;

   always_comb begin
      logic signed [48:0] a49;
      logic signed [48:0] b49;
      for (int i = 0; i < 3; i++) begin
         a49 = $signed({{16{s1_diff_ff[i][32]}}, s1_diff_ff[i]});
         b49 = $signed({{33{s1_ctx_ff.n[i][15]}}, s1_ctx_ff.n[i]});
         s2_prod_in[i] = a49 * b49;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (en) begin
         s2_ctx_ff  <= s1_ctx_ff;
         s2_prod_ff <= s2_prod_in;
      end
   end

   // stage 3: dot product sum
   logic             s3_vld_ff;
   ctx_type          s3_ctx_ff;
   logic [SEP_W-1:0] s3_sep_ff, s3_sep_in;

   assign s3_sep_in = {{2{s2_prod_ff[0][48]}}, s2_prod_ff[0]}
                    + {{2{s2_prod_ff[1][48]}}, s2_prod_ff[1]}
                    + {{2{s2_prod_ff[2][48]}}, s2_prod_ff[2]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff;
      end
      if (en) begin
         s3_ctx_ff <= s2_ctx_ff;
         s3_sep_ff <= s3_sep_in;
      end
   end

   // stage 4: outcome, approach speed and total inverse mass
   logic             s4_vld_ff;
   ctx_type          s4_ctx_ff, s4_ctx_in;
   logic [MAG_W-1:0] s4_mag_ff, s4_mag_in;
   logic [TOT_W-1:0] s4_tot_ff, s4_tot_in;

   always_comb begin
      logic [SEP_W-1:0] neg;
      neg       = -s3_sep_ff;
      s4_mag_in = neg[MAG_W+13:14];
      s4_tot_in = {1'b0, s3_ctx_ff.ima} + {1'b0, s3_ctx_ff.imb};
      s4_ctx_in = s3_ctx_ff;
      if (!s3_sep_ff[SEP_W-1] && (s3_sep_ff != '0)) begin
         s4_ctx_in.outcome = OUT_SEPARATING;
      end else if (s4_tot_in == '0) begin
         s4_ctx_in.outcome = OUT_IMMOVABLE;
      end else begin
         s4_ctx_in.outcome = OUT_IMPULSE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= s3_vld_ff;
      end
      if (en) begin
         s4_ctx_ff <= s4_ctx_in;
         s4_mag_ff <= s4_mag_in;
         s4_tot_ff <= s4_tot_in;
      end
   end

   // stage 5: velocity change, approach speed times (1 + bounce)
   logic             s5_vld_ff;
   ctx_type          s5_ctx_ff;
   logic [DV_W-1:0]  s5_dv_ff, s5_dv_in;
   logic [TOT_W-1:0] s5_tot_ff;
   logic [FAC_W-1:0] s5_fac;

   assign s5_fac   = {1'b0, s4_ctx_ff.bounce} + ONE_Q16;
   assign s5_dv_in = DV_W'(s4_mag_ff) * DV_W'(s5_fac);

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (en) begin
         s5_vld_ff <= s4_vld_ff;
      end
      if (en) begin
         s5_ctx_ff <= s4_ctx_ff;
         s5_dv_ff  <= s5_dv_in;
         s5_tot_ff <= s4_tot_ff;
      end
   end

   // restoring divider, one quotient bit per stage
   logic             div_vld_ff [DIV_N];
   ctx_type          div_ctx_ff [DIV_N];
   logic [DV_W-1:0]  div_dq_ff  [DIV_N];
   logic [TOT_W-1:0] div_rem_ff [DIV_N];
   logic [TOT_W-1:0] div_tot_ff [DIV_N];

   for (genvar k = 0; k < DIV_N; k++) begin : g_div
      logic             vld_prev;
      ctx_type          ctx_prev;
      logic [DV_W-1:0]  dq_prev;
      logic [TOT_W-1:0] rem_prev;
      logic [TOT_W-1:0] tot_prev;
      logic [TOT_W:0]   trial;
      logic             ge;
      logic [TOT_W-1:0] rem_in;
      logic [DV_W-1:0]  dq_in;

      if (k == 0) begin : g_first
         assign vld_prev = s5_vld_ff;
         assign ctx_prev = s5_ctx_ff;
         assign dq_prev  = s5_dv_ff;
         assign rem_prev = '0;
         assign tot_prev = s5_tot_ff;
      end else begin : g_next
         assign vld_prev = div_vld_ff[k-1];
         assign ctx_prev = div_ctx_ff[k-1];
         assign dq_prev  = div_dq_ff[k-1];
         assign rem_prev = div_rem_ff[k-1];
         assign tot_prev = div_tot_ff[k-1];
      end

      // shift in the next dividend bit, subtract when it fits
      always_comb begin
         trial  = {rem_prev, dq_prev[DV_W-1]};
         ge     = (trial >= {1'b0, tot_prev});
         rem_in = ge ? TOT_W'(trial - {1'b0, tot_prev}) : trial[TOT_W-1:0];
         dq_in  = {dq_prev[DV_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_vld_ff[k] <= 1'b0;
         end else if (en) begin
            div_vld_ff[k] <= vld_prev;
         end
         if (en) begin
            div_ctx_ff[k] <= ctx_prev;
            div_dq_ff[k]  <= dq_in;
            div_rem_ff[k] <= rem_in;
            div_tot_ff[k] <= tot_prev;
         end
      end
   end

   // stage m1: partial products of impulse times inverse masses
   logic        m1_vld_ff;
   ctx_type     m1_ctx_ff;
   logic [58:0] m1_pla_ff, m1_pha_ff, m1_plb_ff, m1_phb_ff;
   logic [DV_W-1:0] imp;

   assign imp = div_dq_ff[DIV_N-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
      end else if (en) begin
         m1_vld_ff <= div_vld_ff[DIV_N-1];
      end
      if (en) begin
         m1_ctx_ff <= div_ctx_ff[DIV_N-1];
         m1_pla_ff <= 59'(imp[26:0]) * 59'(div_ctx_ff[DIV_N-1].ima);
         m1_pha_ff <= 59'(imp[DV_W-1:27]) * 59'(div_ctx_ff[DIV_N-1].ima);
         m1_plb_ff <= 59'(imp[26:0]) * 59'(div_ctx_ff[DIV_N-1].imb);
         m1_phb_ff <= 59'(imp[DV_W-1:27]) * 59'(div_ctx_ff[DIV_N-1].imb);
      end
   end

   // stage m2: combine partial products, drop 16 fraction bits
   logic           m2_vld_ff;
   ctx_type        m2_ctx_ff;
   logic [W_W-1:0] m2_wa_ff, m2_wb_ff;
   logic [85:0]    m2_sa, m2_sb;

   assign m2_sa = (86'(m1_pha_ff) << 27) + 86'(m1_pla_ff);
   assign m2_sb = (86'(m1_phb_ff) << 27) + 86'(m1_plb_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_vld_ff <= 1'b0;
      end else if (en) begin
         m2_vld_ff <= m1_vld_ff;
      end
      if (en) begin
         m2_ctx_ff <= m1_ctx_ff;
         m2_wa_ff  <= m2_sa[W_W+15:16];
         m2_wb_ff  <= m2_sb[W_W+15:16];
      end
   end

   // stage m3: scale by the normal magnitude per axis
   logic                 m3_vld_ff;
   ctx_type              m3_ctx_ff;
   logic [2:0][SC_W-1:0] m3_sca_ff, m3_scb_ff, m3_sca_in, m3_scb_in;

   always_comb begin
      logic [15:0] an;
      for (int i = 0; i < 3; i++) begin
         an = m2_ctx_ff.n[i][15] ? 16'(-m2_ctx_ff.n[i]) : m2_ctx_ff.n[i];
         m3_sca_in[i] = SC_W'(m2_wa_ff) * SC_W'(an);
         m3_scb_in[i] = SC_W'(m2_wb_ff) * SC_W'(an);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_vld_ff <= 1'b0;
      end else if (en) begin
         m3_vld_ff <= m2_vld_ff;
      end
      if (en) begin
         m3_ctx_ff <= m2_ctx_ff;
         m3_sca_ff <= m3_sca_in;
         m3_scb_ff <= m3_scb_in;
      end
   end

   // final stage: signed add, saturate, or pass through
   logic [2:0][31:0] fa_in, fb_in, fa_ff, fb_ff;
   outcome_type      outcome_ff;

   always_comb begin
      logic signed [40:0] qa, qb, sa, sb;
      for (int i = 0; i < 3; i++) begin
         qa = $signed({2'b00, m3_sca_ff[i][SC_W-1:14]});
         qb = $signed({2'b00, m3_scb_ff[i][SC_W-1:14]});
         if (m3_ctx_ff.n[i][15]) begin
            qa = -qa;
            qb = -qb;
         end
         sa = $signed({{9{m3_ctx_ff.va[i][31]}}, m3_ctx_ff.va[i]}) + qa;
         sb = $signed({{9{m3_ctx_ff.vb[i][31]}}, m3_ctx_ff.vb[i]}) - qb;
         if (m3_ctx_ff.outcome == OUT_IMPULSE) begin
            fa_in[i] = sat32(sa);
            fb_in[i] = sat32(sb);
         end else begin
            fa_in[i] = m3_ctx_ff.va[i];
            fb_in[i] = m3_ctx_ff.vb[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= m3_vld_ff;
      end
      if (en) begin
         fa_ff      <= fa_in;
         fb_ff      <= fb_in;
         outcome_ff <= m3_ctx_ff.outcome;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_vel_a_x = fa_ff[0];
   assign rsp_new_vel_a_y = fa_ff[1];
   assign rsp_new_vel_a_z = fa_ff[2];
   assign rsp_new_vel_b_x = fb_ff[0];
   assign rsp_new_vel_b_y = fb_ff[1];
   assign rsp_new_vel_b_z = fb_ff[2];
   assign rsp_outcome     = outcome_ff;

   // checks
   `PCI_ASSERT_IMP(a_div_rem_bound, clock, reset,
      div_vld_ff[DIV_N-1] && (div_ctx_ff[DIV_N-1].outcome == OUT_IMPULSE),
      div_rem_ff[DIV_N-1] < div_tot_ff[DIV_N-1], "divider remainder not below divisor")
   `PCI_ASSERT_IMP(a_outcome_code, clock, reset, rsp_valid_ff,
      (outcome_ff == OUT_SEPARATING) || (outcome_ff == OUT_IMMOVABLE) ||
      (outcome_ff == OUT_IMPULSE), "bad outcome code")
   `PCI_ASSERT_NXT(a_freeze, clock, reset, !en,
      $stable(m3_vld_ff) && $stable(div_vld_ff[0]) && $stable(s1_vld_ff),
      "pipeline moved while held")
   `PCI_ASSERT_IMP(a_impulse_total, clock, reset,
      s5_vld_ff && (s5_ctx_ff.outcome == OUT_IMPULSE),
      s5_tot_ff != '0, "impulse with zero total inverse mass")

endmodule
